// ===== rtl/mips_subset_execute_unit_macros.svh =====
// Assertion macros for the execute unit, sampled on clk and quiet during reset.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication
`define MSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mse_pkg.sv =====
// Shared constants, opcode and error codes for the execute unit.
`timescale 1ns / 1ps

package mse_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int REG_COUNT = 32;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_AW    = $clog2(REG_COUNT);

  // Register that holds the top data address after reset
  localparam logic [REG_AW-1:0] SP_REG  = REG_AW'(REG_COUNT - 1);
  localparam logic [31:0]       SP_INIT = 32'(MEM_WORDS - 1);

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_SLT  = 4'd3,
    OP_BEQ  = 4'd4,
    OP_BNE  = 4'd5,
    OP_J    = 4'd6,
    OP_LW   = 4'd7,
    OP_SW   = 4'd8,
    OP_ADDI = 4'd9
  } opcode_t;

  typedef enum logic [2:0] {
    ERR_OK         = 3'd0,
    ERR_ZERO_REG   = 3'd1,
    ERR_LOAD_ADDR  = 3'd2,
    ERR_STORE_ADDR = 3'd3,
    ERR_ILLEGAL    = 3'd4,
    ERR_BAD_TARGET = 3'd5
  } err_t;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

endpackage

// ===== rtl/mips_subset_execute_unit.sv =====
// Execute unit: register bank and data memory with one-request-at-a-time execution.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | decoded instruction fields
//  out_    | output    | out_valid / out_ready | next pc, flags, write-back
//  cfg_    | input     | cfg_valid / cfg_ready | program length (16 bits)
//
// A request is accepted with its bank read and executes in the next cycle; its result
// is registered when execute completes, and the next request can be taken on that edge.
// A load passes through the LOAD state for the data memory read; the next request is
// taken only from idle, after its result. After reset the data memory is zeroed, one
// word a cycle; requests are refused meanwhile, configuration writes are always taken.
// A waiting result holds the next request in execute; forwarding covers a bank
// write and read on the same edge.
`timescale 1ns / 1ps
`include "mips_subset_execute_unit_macros.svh"

module mips_subset_execute_unit
  import mse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_mode,
  input  logic [4:0]         in_dest_reg,
  input  logic [4:0]         in_src1_reg,
  input  logic [4:0]         in_src2_reg,
  input  logic               in_use_immediate,
  input  logic signed [31:0] in_immediate,
  input  logic [15:0]        in_target,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_next_pc,
  output logic               out_finished,
  output logic [2:0]         out_error_code,
  output logic               out_wrote_register,
  output logic [4:0]         out_written_index,
  output logic signed [31:0] out_written_value,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  // ---------------------------------------------------------------------------
  // Control and request registers
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [MEM_AW-1:0]  clr_addr_r;
  logic [15:0]        plen_r;
  logic [15:0]        pc_r;

  logic [3:0]         mode_r;
  logic [REG_AW-1:0]  rd_r;
  logic [REG_AW-1:0]  rs_r;
  logic [REG_AW-1:0]  pb_addr_r;
  logic               use_imm_r;
  logic [31:0]        imm_r;
  logic [15:0]        tgt_r;

  // Register bank, valid bits and last-write forwarding
  logic [31:0]        rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [31:0]        rf_a_q, rf_b_q;
  logic               fwd_vld_r;
  logic [REG_AW-1:0]  fwd_idx_r;
  logic [31:0]        fwd_val_r;

  // Data memory
  logic [31:0]        dmem [MEM_WORDS];
  logic [31:0]        dm_q;

  // Output register
  logic               out_valid_r;
  logic [15:0]        out_next_pc_r;
  logic               out_finished_r;
  logic [2:0]         out_error_code_r;
  logic               out_wrote_r;
  logic [4:0]         out_index_r;
  logic [31:0]        out_value_r;

  // Execute-stage signals
  logic [31:0]        op_a, op_b, opnd_b, addr, mul_lo;
  logic               addr_bad;
  logic [15:0]        pc_inc, exe_next;
  err_t               exe_err;
  logic               exe_wr, exe_load, exe_store;
  logic [31:0]        exe_val;
  logic               out_free, exe_done, load_done, accept;
  logic               rf_we;
  logic [REG_AW-1:0]  rf_widx;
  logic [31:0]        rf_wval;
  logic [15:0]        fin_next;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Operand read: forward the last write, else bank data or its reset value
  // ---------------------------------------------------------------------------
  always_comb begin
    if (fwd_vld_r && fwd_idx_r == rs_r) begin
      op_a = fwd_val_r;
    end else if (rf_vld_r[rs_r]) begin
      op_a = rf_a_q;
    end else begin
      op_a = (rs_r == SP_REG) ? SP_INIT : 32'd0;
    end
    if (fwd_vld_r && fwd_idx_r == pb_addr_r) begin
      op_b = fwd_val_r;
    end else if (rf_vld_r[pb_addr_r]) begin
      op_b = rf_b_q;
    end else begin
      op_b = (pb_addr_r == SP_REG) ? SP_INIT : 32'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute decode
  // ---------------------------------------------------------------------------
  assign opnd_b   = use_imm_r ? imm_r : op_b;
  assign addr     = op_a + imm_r;
  assign addr_bad = addr >= 32'(MEM_WORDS);
  assign mul_lo   = op_a * opnd_b;
  assign pc_inc   = pc_r + 16'd1;

  always_comb begin
    exe_err   = ERR_OK;
    exe_wr    = 1'b0;
    exe_load  = 1'b0;
    exe_store = 1'b0;
    exe_val   = 32'd0;
    exe_next  = pc_inc;
    unique case (mode_r) inside
      OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI: begin
        if (rd_r == '0) begin
          exe_err = ERR_ZERO_REG;
        end else begin
          exe_wr = 1'b1;
          case (mode_r)
            OP_ADD:  exe_val = op_a + opnd_b;
            OP_SUB:  exe_val = op_a - opnd_b;
            OP_MUL:  exe_val = mul_lo;
            OP_SLT:  exe_val = {31'd0, $signed(op_a) < $signed(opnd_b)};
            default: exe_val = op_a + imm_r;
          endcase
        end
      end
      OP_BEQ, OP_BNE, OP_J: begin
        if (tgt_r > plen_r) begin
          exe_err = ERR_BAD_TARGET;
        end else if (mode_r == OP_J ||
                     (mode_r == OP_BEQ && op_a == opnd_b) ||
                     (mode_r == OP_BNE && op_a != opnd_b)) begin
          exe_next = tgt_r;
        end
      end
      OP_LW: begin
        if (rd_r == '0) begin
          exe_err = ERR_ZERO_REG;
        end else if (addr_bad) begin
          exe_err = ERR_LOAD_ADDR;
        end else begin
          exe_load = 1'b1;
        end
      end
      OP_SW: begin
        if (addr_bad) begin
          exe_err = ERR_STORE_ADDR;
        end else begin
          exe_store = 1'b1;
        end
      end
      default: exe_err = ERR_ILLEGAL;
    endcase
  end

  // Completion and acceptance
  assign exe_done  = (state_r == S_EXEC) && !exe_load && out_free;
  assign load_done = (state_r == S_LOAD) && out_free;
  assign in_ready  = (state_r == S_IDLE) || exe_done;
  assign accept    = in_valid && in_ready;
  assign fin_next  = load_done ? pc_inc : exe_next;

  // Register bank write-back
  assign rf_we   = (exe_done && exe_wr) || load_done;
  assign rf_widx = rd_r;
  assign rf_wval = load_done ? dm_q : exe_val;

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_addr_r == MEM_AW'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC: begin
        if (exe_load) begin
          state_nxt = S_LOAD;
        end else if (exe_done && !accept) begin
          state_nxt = S_IDLE;
        end
      end
      S_LOAD:  if (load_done) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      plen_r     <= '0;
      pc_r       <= '0;
      rf_vld_r   <= '0;
      fwd_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + MEM_AW'(1);
      if (cfg_valid && cfg_ready) plen_r <= cfg_data;
      if (exe_done || load_done) pc_r <= fin_next;
      if (rf_we) begin
        rf_vld_r[rf_widx] <= 1'b1;
        fwd_vld_r         <= 1'b1;
      end
      if (exe_done || load_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request fields, latched at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      rd_r      <= in_dest_reg;
      rs_r      <= in_src1_reg;
      pb_addr_r <= (in_mode == OP_SW) ? in_dest_reg : in_src2_reg;
      use_imm_r <= in_use_immediate;
      imm_r     <= in_immediate;
      tgt_r     <= in_target;
    end
  end

  // ---------------------------------------------------------------------------
  // Register bank: one write port, two synchronous read ports
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_widx] <= rf_wval;
    if (accept) begin
      rf_a_q <= rf_mem[in_src1_reg];
      rf_b_q <= rf_mem[(in_mode == OP_SW) ? in_dest_reg : in_src2_reg];
    end
  end

  // Last bank write, for a read on the same edge
  always_ff @(posedge clk) begin
    if (rf_we) begin
      fwd_idx_r <= rf_widx;
      fwd_val_r <= rf_wval;
    end
  end

  // ---------------------------------------------------------------------------
  // Data memory: clearing pass, store, synchronous load read
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      dmem[clr_addr_r] <= 32'd0;
    end else if (exe_done && exe_store) begin
      dmem[addr[MEM_AW-1:0]] <= op_b;
    end
    if (state_r == S_EXEC && exe_load) dm_q <= dmem[addr[MEM_AW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (exe_done || load_done) begin
      out_next_pc_r    <= fin_next;
      out_finished_r   <= fin_next >= plen_r;
      out_error_code_r <= load_done ? ERR_OK : exe_err;
      out_wrote_r      <= rf_we;
      out_index_r      <= rf_we ? rd_r : 5'd0;
      out_value_r      <= rf_we ? rf_wval : 32'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_pc        = out_next_pc_r;
  assign out_finished       = out_finished_r;
  assign out_error_code     = out_error_code_r;
  assign out_wrote_register = out_wrote_r;
  assign out_written_index  = out_index_r;
  assign out_written_value  = $signed(out_value_r);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MSE_ASSERT_NOW(a_no_accept_clear, state_r == S_CLEAR, !in_ready, "request during clear")
  `MSE_ASSERT_NOW(a_no_r0_write, out_valid && out_wrote_register, out_written_index != 5'd0, "r0 written")
  `MSE_ASSERT_NOW(a_err_no_write, out_valid && out_error_code != ERR_OK, !out_wrote_register, "write with error")
  `MSE_ASSERT_NEXT(a_idle_accept, state_r == S_IDLE && in_valid, state_r == S_EXEC, "accept lost")

endmodule
